/* rtl/cdad_pkg.sv */
// Shared definitions for the calendar date add and difference block.
// Field widths, day-number bounds, operation codes and calendar tables.
// No dependencies.
package cdad_pkg;

	// Port field widths
	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int OFFSET_W = 23;
	localparam int DIFF_W   = 22;

	// Internal widths
	localparam int DN_W   = 23;  // day number counted from 1 March of year -400
	localparam int T_W    = 22;  // in-range day number
	localparam int DOE_W  = 18;  // day of a 400-year era
	localparam int ERA_W  = 5;
	localparam int YOE_W  = 9;   // year of era
	localparam int DOY_W  = 9;   // day of year, March based
	localparam int Q100_W = 8;   // year / 100

	localparam logic [DIFF_W-1:0] DIFF_MAX = '1;

	// Day numbers of 0000-01-01 and 9999-12-31
	localparam int DN_LO = 365 * 399 + 399 / 4 - 399 / 100 + 399 / 400 + 306;
	localparam int DN_HI = 365 * 10399 + 10399 / 4 - 10399 / 100 + 10399 / 400 + 305;

	localparam int ERA_DAYS = 146097;

	// Substitute for an invalid date
	localparam logic [YEAR_W-1:0]  YEAR_DEFAULT  = 14'd1970;
	localparam logic [MONTH_W-1:0] MONTH_DEFAULT = 4'd1;
	localparam logic [DAY_W-1:0]   DAY_DEFAULT   = 5'd1;

	// Clamp bounds
	localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_MAX   = 5'd31;

	typedef enum logic {
		FUNC_ADD  = 1'b0,
		FUNC_DIFF = 1'b1
	} func_t;

	// Side information carried down the date recovery stages
	typedef struct packed {
		logic              func;
		logic              clamp_lo;
		logic              clamp_hi;
		logic [DIFF_W-1:0] diff;
	} side_t;

	// Length of a month; zero for a month code outside 1..12
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// First day of a month within a March-based year (index 0 is March)
	function automatic logic [DOY_W-1:0] mp_start(input logic [MONTH_W-1:0] mp);
		logic [DOY_W-1:0] s;
		case (mp)
			4'd0:    s = 9'd0;
			4'd1:    s = 9'd31;
			4'd2:    s = 9'd61;
			4'd3:    s = 9'd92;
			4'd4:    s = 9'd122;
			4'd5:    s = 9'd153;
			4'd6:    s = 9'd184;
			4'd7:    s = 9'd214;
			4'd8:    s = 9'd245;
			4'd9:    s = 9'd275;
			4'd10:   s = 9'd306;
			4'd11:   s = 9'd337;
			default: s = 9'd0;
		endcase
		return s;
	endfunction

endpackage

/* rtl/calendar_date_add_and_difference.sv */
// Top level: proleptic Gregorian date add and day difference, fully pipelined.
// Depends on cdad_pkg.
//
// channel  direction  handshake               payload
// in       sink       in_valid / in_ready     func, year, month, day, offset, other_*
// out      source     out_valid / out_ready   res_year, res_month, res_day, difference, clamped
//
// One item per cycle while the output is not stalled; 13 register stages, the last
// of them being the output register.
// Latency is set by the day-number to date conversion: each constant division
// is one reciprocal multiply followed by a register.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stalled result holds in the output register; empty stages still fill, so
// input is taken while earlier items wait.
module calendar_date_add_and_difference (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                func,
	input  logic [cdad_pkg::YEAR_W-1:0]         year,
	input  logic [cdad_pkg::MONTH_W-1:0]        month,
	input  logic [cdad_pkg::DAY_W-1:0]          day,
	input  logic signed [cdad_pkg::OFFSET_W-1:0] offset,
	input  logic [cdad_pkg::YEAR_W-1:0]         other_year,
	input  logic [cdad_pkg::MONTH_W-1:0]        other_month,
	input  logic [cdad_pkg::DAY_W-1:0]          other_day,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [cdad_pkg::YEAR_W-1:0]         res_year,
	output logic [cdad_pkg::MONTH_W-1:0]        res_month,
	output logic [cdad_pkg::DAY_W-1:0]          res_day,
	output logic [cdad_pkg::DIFF_W-1:0]         difference,
	output logic                                clamped
);
	import cdad_pkg::*;

	localparam int NSTG = 13;

	// Reciprocals for exact division by constants (rounded up, shift = N + ceil(log2 d))
	localparam logic [14:0] RECIP_100  = 15'(((1 << 21) + 99) / 100);
	localparam logic [22:0] RECIP_ERA  = 23'(((64'd1 << 40) + 146096) / 146097);
	localparam logic [18:0] RECIP_1460 = 19'(((1 << 29) + 1459) / 1460);
	localparam logic [18:0] RECIP_365  = 19'(((1 << 27) + 364) / 365);
	localparam logic [11:0] RECIP_153  = 12'(((1 << 19) + 152) / 153);

	typedef struct packed {
		logic [14:0]        sy;
		logic [Q100_W-1:0]  c100;
		logic [DOY_W-1:0]   doy;
	} prep_t;

	// Validate a date, substitute the default if needed, and split it for the day number
	function automatic prep_t date_prep(input logic [YEAR_W-1:0] y,
			input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d,
			input logic [Q100_W-1:0] q100);
		logic               z100;
		logic               leap;
		logic               ok;
		logic [YEAR_W-1:0]  ye;
		logic [MONTH_W-1:0] me;
		logic [MONTH_W-1:0] mp;
		logic [DAY_W-1:0]   de;
		logic [Q100_W-1:0]  qe;
		logic               z100e;
		logic               adj;
		prep_t              r;
		z100 = (y == 14'({6'd0, q100} * 14'd100));
		leap = (y[1:0] == 2'b00) && (!z100 || (q100[1:0] == 2'b00));
		ok   = (m >= 4'd1) && (m <= 4'd12) && (d != 5'd0) && (d <= month_len(m, leap));
		if (ok) begin
			ye    = y;
			me    = m;
			de    = d;
			qe    = q100;
			z100e = z100;
		end else begin
			ye    = YEAR_DEFAULT;
			me    = MONTH_DEFAULT;
			de    = DAY_DEFAULT;
			qe    = 8'd19;
			z100e = 1'b0;
		end
		adj    = (me <= 4'd2);
		mp     = adj ? (me + 4'd9) : (me - 4'd3);
		r.sy   = 15'(ye) + 15'd400 - 15'(adj);
		r.c100 = qe + 8'd4 - 8'(adj && z100e);
		r.doy  = mp_start(mp) + 9'(de) - 9'd1;
		return r;
	endfunction

	function automatic logic [DN_W-1:0] day_num(input prep_t p);
		return 23'({8'd0, p.sy} * 23'd365) + 23'(p.sy >> 2) - 23'(p.c100)
			+ 23'(p.c100 >> 2) + 23'(p.doy);
	endfunction

	// Stage handshake: a stage advances when the output is ready or when it or any later stage is empty
	logic [NSTG:1] stg_vld_q;
	logic [NSTG:1] adv;

	for (genvar k = 1; k <= NSTG; k++) begin : g_adv
		assign adv[k] = out_ready | ~(&stg_vld_q[NSTG:k]);
	end

	assign in_ready  = adv[1];
	assign out_valid = stg_vld_q[NSTG];

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else begin
			if (adv[1]) begin
				stg_vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (adv[k]) begin
					stg_vld_q[k] <= stg_vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: input register
	logic                       func_s1;
	logic [YEAR_W-1:0]          year_a_s1, year_b_s1;
	logic [MONTH_W-1:0]         month_a_s1, month_b_s1;
	logic [DAY_W-1:0]           day_a_s1, day_b_s1;
	logic signed [OFFSET_W-1:0] offset_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			func_s1    <= func;
			year_a_s1  <= year;
			month_a_s1 <= month;
			day_a_s1   <= day;
			offset_s1  <= offset;
			year_b_s1  <= other_year;
			month_b_s1 <= other_month;
			day_b_s1   <= other_day;
		end
	end

	// Stage 2: year / 100 for both dates
	logic [28:0]                q100_prod_a, q100_prod_b;
	logic                       func_s2;
	logic [YEAR_W-1:0]          year_a_s2, year_b_s2;
	logic [MONTH_W-1:0]         month_a_s2, month_b_s2;
	logic [DAY_W-1:0]           day_a_s2, day_b_s2;
	logic signed [OFFSET_W-1:0] offset_s2;
	logic [Q100_W-1:0]          q100_a_s2, q100_b_s2;

	assign q100_prod_a = {15'd0, year_a_s1} * {14'd0, RECIP_100};
	assign q100_prod_b = {15'd0, year_b_s1} * {14'd0, RECIP_100};

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			func_s2    <= func_s1;
			year_a_s2  <= year_a_s1;
			month_a_s2 <= month_a_s1;
			day_a_s2   <= day_a_s1;
			year_b_s2  <= year_b_s1;
			month_b_s2 <= month_b_s1;
			day_b_s2   <= day_b_s1;
			offset_s2  <= offset_s1;
			q100_a_s2  <= q100_prod_a[28:21];
			q100_b_s2  <= q100_prod_b[28:21];
		end
	end

	// Stage 3: validate dates and split into shifted year, centuries, day of year
	logic                       func_s3;
	logic signed [OFFSET_W-1:0] offset_s3;
	prep_t                      prep_a_s3, prep_b_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			func_s3   <= func_s2;
			offset_s3 <= offset_s2;
			prep_a_s3 <= date_prep(year_a_s2, month_a_s2, day_a_s2, q100_a_s2);
			prep_b_s3 <= date_prep(year_b_s2, month_b_s2, day_b_s2, q100_b_s2);
		end
	end

	// Stage 4: linear day numbers
	logic                       func_s4;
	logic signed [OFFSET_W-1:0] offset_s4;
	logic [DN_W-1:0]            dn_a_s4, dn_b_s4;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			func_s4   <= func_s3;
			offset_s4 <= offset_s3;
			dn_a_s4   <= day_num(prep_a_s3);
			dn_b_s4   <= day_num(prep_b_s3);
		end
	end

	// Stage 5: add offset with range check, or absolute difference with saturation
	logic signed [24:0] t_sum;
	logic signed [23:0] d_sub;
	logic [23:0]        d_abs;
	side_t              side_nxt;
	side_t              side_s5;
	logic [T_W-1:0]     t_s5;

	always_comb begin
		t_sum             = $signed({2'b00, dn_a_s4}) + 25'(offset_s4);
		d_sub             = $signed({1'b0, dn_a_s4}) - $signed({1'b0, dn_b_s4});
		d_abs             = d_sub[23] ? 24'(-d_sub) : 24'(d_sub);
		side_nxt.func     = func_s4;
		side_nxt.clamp_lo = (func_s4 == FUNC_ADD) && (t_sum < 25'(DN_LO));
		side_nxt.clamp_hi = (func_s4 == FUNC_ADD) && (t_sum > 25'(DN_HI));
		if (func_s4 == FUNC_ADD) begin
			side_nxt.diff = '0;
		end else if (d_abs > {2'b00, DIFF_MAX}) begin
			side_nxt.diff = DIFF_MAX;
		end else begin
			side_nxt.diff = d_abs[DIFF_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			side_s5 <= side_nxt;
			t_s5    <= t_sum[T_W-1:0];
		end
	end

	// Stage 6: era = t / 146097
	logic [44:0]      era_prod;
	side_t            side_s6;
	logic [T_W-1:0]   t_s6;
	logic [ERA_W-1:0] era_s6;

	assign era_prod = {23'd0, t_s5} * {22'd0, RECIP_ERA};

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			side_s6 <= side_s5;
			t_s6    <= t_s5;
			era_s6  <= era_prod[44:40];
		end
	end

	// Stage 7: day of era
	side_t            side_s7;
	logic [ERA_W-1:0] era_s7;
	logic [DOE_W-1:0] doe_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			side_s7 <= side_s6;
			era_s7  <= era_s6;
			doe_s7  <= 18'(t_s6 - 22'({17'd0, era_s6} * 22'(ERA_DAYS)));
		end
	end

	// Stage 8: four-year, century and era corrections
	logic [36:0]      a_prod;
	logic [2:0]       b_cnt;
	side_t            side_s8;
	logic [ERA_W-1:0] era_s8;
	logic [DOE_W-1:0] doe_s8;
	logic [6:0]       a_s8;
	logic [2:0]       b_s8;
	logic             c_s8;

	assign a_prod = {19'd0, doe_s7} * {18'd0, RECIP_1460};
	assign b_cnt  = 3'(doe_s7 >= 18'd36524) + 3'(doe_s7 >= 18'd73048)
		+ 3'(doe_s7 >= 18'd109572) + 3'(doe_s7 >= 18'd146096);

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			side_s8 <= side_s7;
			era_s8  <= era_s7;
			doe_s8  <= doe_s7;
			a_s8    <= a_prod[35:29];
			b_s8    <= b_cnt;
			c_s8    <= (doe_s7 == 18'd146096);
		end
	end

	// Stage 9: day count normalised to 365-day years
	side_t            side_s9;
	logic [ERA_W-1:0] era_s9;
	logic [DOE_W-1:0] doe_s9;
	logic [DOE_W-1:0] n_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			side_s9 <= side_s8;
			era_s9  <= era_s8;
			doe_s9  <= doe_s8;
			n_s9    <= doe_s8 - 18'(a_s8) + 18'(b_s8) - 18'(c_s8);
		end
	end

	// Stage 10: year of era
	logic [36:0]      yoe_prod;
	side_t            side_s10;
	logic [ERA_W-1:0] era_s10;
	logic [DOE_W-1:0] doe_s10;
	logic [YOE_W-1:0] yoe_s10;

	assign yoe_prod = {19'd0, n_s9} * {18'd0, RECIP_365};

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			side_s10 <= side_s9;
			era_s10  <= era_s9;
			doe_s10  <= doe_s9;
			yoe_s10  <= yoe_prod[35:27];
		end
	end

	// Stage 11: day of year
	logic [1:0]       yoe_c100;
	side_t            side_s11;
	logic [ERA_W-1:0] era_s11;
	logic [YOE_W-1:0] yoe_s11;
	logic [DOY_W-1:0] doy_s11;

	assign yoe_c100 = 2'(yoe_s10 >= 9'd100) + 2'(yoe_s10 >= 9'd200) + 2'(yoe_s10 >= 9'd300);

	always_ff @(posedge clk) begin
		if (adv[11]) begin
			side_s11 <= side_s10;
			era_s11  <= era_s10;
			yoe_s11  <= yoe_s10;
			doy_s11  <= 9'(doe_s10 - (18'({9'd0, yoe_s10} * 18'd365) + 18'(yoe_s10 >> 2)
				- 18'(yoe_c100)));
		end
	end

	// Stage 12: March-based month index
	logic [10:0]        mp_num;
	logic [22:0]        mp_prod;
	side_t              side_s12;
	logic [ERA_W-1:0]   era_s12;
	logic [YOE_W-1:0]   yoe_s12;
	logic [DOY_W-1:0]   doy_s12;
	logic [MONTH_W-1:0] mp_s12;

	assign mp_num  = 11'({2'd0, doy_s11} * 11'd5) + 11'd2;
	assign mp_prod = {12'd0, mp_num} * {11'd0, RECIP_153};

	always_ff @(posedge clk) begin
		if (adv[12]) begin
			side_s12 <= side_s11;
			era_s12  <= era_s11;
			yoe_s12  <= yoe_s11;
			doy_s12  <= doy_s11;
			mp_s12   <= mp_prod[22:19];
		end
	end

	// Stage 13: assemble the calendar date and select the result
	logic [MONTH_W-1:0] cal_month;
	logic [DAY_W-1:0]   cal_day;
	logic [YEAR_W-1:0]  cal_year;
	logic [YEAR_W-1:0]  res_year_nxt;
	logic [MONTH_W-1:0] res_month_nxt;
	logic [DAY_W-1:0]   res_day_nxt;
	logic               clamped_nxt;
	logic [YEAR_W-1:0]  res_year_s13;
	logic [MONTH_W-1:0] res_month_s13;
	logic [DAY_W-1:0]   res_day_s13;
	logic [DIFF_W-1:0]  difference_s13;
	logic               clamped_s13;

	always_comb begin
		cal_day   = 5'(doy_s12 - mp_start(mp_s12) + 9'd1);
		cal_month = (mp_s12 < 4'd10) ? (mp_s12 + 4'd3) : (mp_s12 - 4'd9);
		cal_year  = 14'(yoe_s12) + 14'({9'd0, era_s12} * 14'd400)
			+ 14'(cal_month <= 4'd2) - 14'd400;
		if (side_s12.func == FUNC_DIFF) begin
			res_year_nxt  = '0;
			res_month_nxt = '0;
			res_day_nxt   = '0;
			clamped_nxt   = 1'b0;
		end else if (side_s12.clamp_lo) begin
			res_year_nxt  = '0;
			res_month_nxt = MONTH_DEFAULT;
			res_day_nxt   = DAY_DEFAULT;
			clamped_nxt   = 1'b1;
		end else if (side_s12.clamp_hi) begin
			res_year_nxt  = YEAR_MAX;
			res_month_nxt = MONTH_MAX;
			res_day_nxt   = DAY_MAX;
			clamped_nxt   = 1'b1;
		end else begin
			res_year_nxt  = cal_year;
			res_month_nxt = cal_month;
			res_day_nxt   = cal_day;
			clamped_nxt   = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[13]) begin
			res_year_s13   <= res_year_nxt;
			res_month_s13  <= res_month_nxt;
			res_day_s13    <= res_day_nxt;
			difference_s13 <= side_s12.diff;
			clamped_s13    <= clamped_nxt;
		end
	end

	assign res_year   = res_year_s13;
	assign res_month  = res_month_s13;
	assign res_day    = res_day_s13;
	assign difference = difference_s13;
	assign clamped    = clamped_s13;

endmodule

/* rtl/cdad_checker.sv */
// Port-level checks for the calendar date add and difference block, with its bind.
// Depends on cdad_pkg and on the ports of calendar_date_add_and_difference.
// Sees only the top level's ports.
module cdad_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [cdad_pkg::YEAR_W-1:0]          res_year,
	input logic [cdad_pkg::MONTH_W-1:0]         res_month,
	input logic [cdad_pkg::DAY_W-1:0]           res_day,
	input logic [cdad_pkg::DIFF_W-1:0]          difference,
	input logic                                 clamped
);
	import cdad_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_year) && $stable(res_month)
			&& $stable(res_day) && $stable(difference) && $stable(clamped))
		else $error("stalled result changed");

	// A difference item carries no date and no clamp flag
	a_diff_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_month == '0 |-> res_year == '0 && res_day == '0 && !clamped)
		else $error("difference item with date fields set");

	// An add item carries date fields within their bounds and no difference
	a_add_date: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_month != '0 |-> res_month <= MONTH_MAX && res_day != '0
			&& res_day <= DAY_MAX && res_year <= YEAR_MAX && difference == '0)
		else $error("add item with illegal date");

	// A clamped item sits on one of the two bounds
	a_clamp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clamped |->
			(res_year == '0 && res_month == MONTH_DEFAULT && res_day == DAY_DEFAULT)
			|| (res_year == YEAR_MAX && res_month == MONTH_MAX && res_day == DAY_MAX))
		else $error("clamped item not on a bound");

endmodule

bind calendar_date_add_and_difference cdad_checker u_cdad_checker (.*);
